// ===== rtl/core/pcs_pkg.sv =====
// shared widths, register indexes, reset values and pipeline word types
// for the ptp clock servo; no dependencies
package pcs_pkg;

   localparam int OFFSET_W    = 48;
   localparam int GAIN_W      = 24;
   localparam int MAXF_W      = 28;
   localparam int LIMIT_W     = 47;
   localparam int FREQ_W      = 45;
   localparam int PPM_W       = 36;
   localparam int PROD_W      = 60;
   localparam int INTEG_W     = 46;
   localparam int QUOT_W      = 35;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 47;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FREQ   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LIMIT = 4'd3;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 24'd734003;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 24'd314573;
   localparam logic [MAXF_W-1:0]  MAX_FREQ_RST   = 28'd500000;
   localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 47'd1000000;

   typedef struct packed {
      logic                       valid;
      logic                       gt;
      logic signed [OFFSET_W-1:0] amt;
   } pcs_front_type;

   typedef struct packed {
      logic                       valid;
      logic                       is_step;
      logic signed [OFFSET_W-1:0] step_amount;
      logic signed [FREQ_W-1:0]   freq;
   } pcs_back_type;

endpackage

// ===== rtl/core/pcs_gain_mult.sv =====
// offset magnitude times unsigned q4.20 gain, saturated and shifted to q.16
// four register stages; depends on pcs_pkg
module pcs_gain_mult import pcs_pkg::*; (
   input  logic                     clock,
   input  logic                     adv,
   input  logic [OFFSET_W-1:0]      mag,
   input  logic                     neg,
   input  logic [GAIN_W-1:0]        gain,
   output logic signed [PROD_W-1:0] prod
);

   localparam int HALF_W = OFFSET_W / 2;
   localparam int PP_W   = HALF_W + GAIN_W;
   localparam int FULL_W = OFFSET_W + GAIN_W;
   localparam int SAT_W  = 63;
   localparam logic [FULL_W-1:0] PROD_SAT = FULL_W'(64'h4000_0000_0000_0000);

   logic [PP_W-1:0]         lo_ff, lo_in, lo2_ff, hi_ff, hi_in;
   logic [HALF_W-1:0]       mag_hi_ff;
   logic                    neg1_ff, neg2_ff, neg3_ff;
   logic [FULL_W-1:0]       sum;
   logic [SAT_W-1:0]        sat_ff, sat_in;
   logic signed [SAT_W:0]   sat_s, shr;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      lo_in  = PP_W'(mag[HALF_W-1:0]) * PP_W'(gain);
      hi_in  = PP_W'(mag_hi_ff) * PP_W'(gain);
      sum    = {hi_ff, HALF_W'(0)} + FULL_W'(lo2_ff);
      sat_in = (sum > PROD_SAT) ? PROD_SAT[SAT_W-1:0] : sum[SAT_W-1:0];
      sat_s  = signed'({1'b0, sat_ff});
      // floor shift of the negated value rounds the magnitude up
      shr     = neg3_ff ? ((-sat_s) >>> 4) : (sat_s >>> 4);
      prod_in = shr[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff     <= lo_in;
         mag_hi_ff <= mag[OFFSET_W-1:HALF_W];
         neg1_ff   <= neg;
         hi_ff     <= hi_in;
         lo2_ff    <= lo_ff;
         neg2_ff   <= neg1_ff;
         sat_ff    <= sat_in;
         neg3_ff   <= neg2_ff;
         prod_ff   <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/pcs_pi_update.sv =====
// servo state: first-sample step test, clamped integral, clamped pi sum
// two register stages plus the integral and first-sample flag; depends on pcs_pkg
module pcs_pi_update import pcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  pcs_front_type            front,
   input  logic signed [PROD_W-1:0] kp_prod,
   input  logic signed [PROD_W-1:0] ki_prod,
   input  logic [MAXF_W-1:0]        max_freq,
   output pcs_back_type             back
);

   localparam int SUM_W = PROD_W + 1;
   localparam int LIM_W = MAXF_W + 16;

   function automatic logic signed [SUM_W-1:0] clamp_sum(
      input logic signed [SUM_W-1:0] v,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [SUM_W-1:0] lim_s;
      lim_s = signed'(SUM_W'(lim));
      if (v > lim_s) return lim_s;
      else if (v < -lim_s) return -lim_s;
      else return v;
   endfunction

   logic [LIM_W-1:0]           lim;
   logic                       do_step;
   logic signed [SUM_W-1:0]    isum, iclamp, fsum, fclamp;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic                       first_ff, first_in;
   logic                       a_valid_ff, a_step_ff;
   logic signed [OFFSET_W-1:0] a_amt_ff, a_amt_in;
   logic signed [PROD_W-1:0]   a_kp_ff;
   pcs_back_type               back_ff, back_in;

   always_comb begin
      lim      = {max_freq, 16'b0};
      do_step  = first_ff & front.gt;
      isum     = SUM_W'(integ_ff) + SUM_W'(ki_prod);
      iclamp   = clamp_sum(isum, lim);
      integ_in = integ_ff;
      first_in = first_ff;
      if (front.valid) begin
         first_in = do_step;
         integ_in = do_step ? '0 : iclamp[INTEG_W-1:0];
      end
      a_amt_in = do_step ? front.amt : '0;

      // integ_ff already holds this word's updated integral
      fsum   = SUM_W'(a_kp_ff) + SUM_W'(integ_ff);
      fclamp = clamp_sum(fsum, lim);
      back_in.valid       = a_valid_ff;
      back_in.is_step     = a_step_ff;
      back_in.step_amount = a_amt_ff;
      back_in.freq        = a_step_ff ? '0 : fclamp[FREQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         first_ff      <= 1'b1;
         a_valid_ff    <= 1'b0;
         back_ff.valid <= 1'b0;
      end else if (adv) begin
         integ_ff      <= integ_in;
         first_ff      <= first_in;
         a_valid_ff    <= front.valid;
         back_ff.valid <= back_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_step_ff           <= do_step;
         a_amt_ff            <= a_amt_in;
         a_kp_ff             <= kp_prod;
         back_ff.is_step     <= back_in.is_step;
         back_ff.step_amount <= back_in.step_amount;
         back_ff.freq        <= back_in.freq;
      end
   end

   assign back = back_ff;

endmodule

// ===== rtl/core/pcs_div1000.sv =====
// magnitude of a q.16 frequency divided by 1000, truncated
// two reciprocal multiplies on 22-bit halves, four register stages; depends on pcs_pkg
module pcs_div1000 import pcs_pkg::*; (
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [FREQ_W-1:0] freq,
   output logic [QUOT_W-1:0]        quot
);

   localparam int MAG_W   = FREQ_W - 1;
   localparam int HI_W    = MAG_W / 2;
   localparam int LO_W    = MAG_W - HI_W;
   localparam int REM_W   = 10;
   localparam int X2_W    = REM_W + LO_W;
   localparam int RCP_W   = 33;
   localparam int SHIFT   = 42;
   localparam int Q1_W    = QUOT_W - LO_W;
   localparam logic [RCP_W-1:0] RECIP   = 33'd4398046512;
   localparam logic [HI_W-1:0]  DIVISOR = 22'd1000;

   logic [FREQ_W-1:0]     neg_freq;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic [HI_W+RCP_W-1:0] p1;
   logic [X2_W+RCP_W-1:0] p2;
   logic [Q1_W-1:0]       q1_ff, q1_in, q1b_ff, q1c_ff;
   logic [LO_W-1:0]       lo_ff, lo2_ff, q2_ff, q2_in;
   logic [HI_W-1:0]       hi_ff, q1k, diff;
   logic [X2_W-1:0]       x2_ff, x2_in;

   always_comb begin
      neg_freq = -freq;
      mag_in   = freq[FREQ_W-1] ? neg_freq[MAG_W-1:0] : freq[MAG_W-1:0];
      p1       = (HI_W+RCP_W)'(mag_ff[MAG_W-1:LO_W]) * (HI_W+RCP_W)'(RECIP);
      q1_in    = p1[SHIFT+Q1_W-1:SHIFT];
      q1k      = HI_W'(q1_ff) * DIVISOR;
      diff     = hi_ff - q1k;
      x2_in    = {diff[REM_W-1:0], lo_ff};
      p2       = (X2_W+RCP_W)'(x2_ff) * (X2_W+RCP_W)'(RECIP);
      q2_in    = p2[SHIFT+LO_W-1:SHIFT];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
         q1_ff  <= q1_in;
         hi_ff  <= mag_ff[MAG_W-1:LO_W];
         lo_ff  <= mag_ff[LO_W-1:0];
         x2_ff  <= x2_in;
         q1b_ff <= q1_ff;
         q2_ff  <= q2_in;
         q1c_ff <= q1b_ff;
      end
   end

   assign quot = {q1c_ff, q2_ff};

endmodule

// ===== rtl/core/ptp_pi_clock_servo.sv =====
// ptp pi clock servo: one offset word in, one step or frequency word out.
// the result passes the input register, the split 48x24 gain multiplies (4 stages),
// the integral update, the output clamp, the reciprocal divide by 1000 (4 stages)
// and the output register. throughput: one word per cycle unless the output stalls.
// reset clears the integral, arms the first-sample flag, loads default gains
// and limits and empties the pipeline; a stalled output holds the whole pipeline.
module ptp_pi_clock_servo import pcs_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [OFFSET_W-1:0] req_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_step,
   output logic signed [FREQ_W-1:0]   rsp_freq_q16,
   output logic signed [PPM_W-1:0]    rsp_ppm_q16,
   output logic signed [OFFSET_W-1:0] rsp_step_amount,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int FRONT_D = 4;
   localparam int BACK_D  = 4;
   localparam logic [OFFSET_W-1:0] OFF_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
   localparam logic [OFFSET_W-1:0] AMT_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};

   logic                       adv;
   logic [GAIN_W-1:0]          prop_gain_ff, integ_gain_ff;
   logic [MAXF_W-1:0]          max_freq_ff;
   logic [LIMIT_W-1:0]         step_limit_ff;
   logic                       v0_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic [OFFSET_W-1:0]        neg_off, mag0;
   logic                       neg0;
   pcs_front_type              front_in;
   pcs_front_type              front_ff [FRONT_D];
   logic signed [PROD_W-1:0]   kp_prod, ki_prod;
   pcs_back_type               back;
   pcs_back_type               back_ff [BACK_D];
   logic [QUOT_W-1:0]          quot;
   logic [PPM_W-1:0]           ppm_in;
   logic                       rsp_valid_ff;
   logic                       rsp_is_step_ff;
   logic signed [FREQ_W-1:0]   rsp_freq_ff;
   logic signed [PPM_W-1:0]    rsp_ppm_ff;
   logic signed [OFFSET_W-1:0] rsp_amt_ff;

   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~adv;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         max_freq_ff   <= MAX_FREQ_RST;
         step_limit_ff <= STEP_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MAX_FREQ:   max_freq_ff   <= csr_wdata[MAXF_W-1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register and magnitude / threshold test
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff <= req_offset;
      end
   end

   always_comb begin
      neg_off        = -off_ff;
      neg0           = off_ff[OFFSET_W-1];
      mag0           = neg0 ? neg_off : off_ff;
      front_in.valid = v0_ff;
      front_in.gt    = mag0 > OFFSET_W'(step_limit_ff);
      // most negative offset has no negation, saturate the step
      front_in.amt   = (off_ff == OFF_MIN) ? AMT_MAX : neg_off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRONT_D; i++) front_ff[i].valid <= 1'b0;
         for (int i = 0; i < BACK_D; i++) back_ff[i].valid <= 1'b0;
      end else if (adv) begin
         front_ff[0].valid <= front_in.valid;
         for (int i = 1; i < FRONT_D; i++) front_ff[i].valid <= front_ff[i-1].valid;
         back_ff[0].valid <= back.valid;
         for (int i = 1; i < BACK_D; i++) back_ff[i].valid <= back_ff[i-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff[0].gt  <= front_in.gt;
         front_ff[0].amt <= front_in.amt;
         for (int i = 1; i < FRONT_D; i++) begin
            front_ff[i].gt  <= front_ff[i-1].gt;
            front_ff[i].amt <= front_ff[i-1].amt;
         end
         back_ff[0].is_step     <= back.is_step;
         back_ff[0].step_amount <= back.step_amount;
         back_ff[0].freq        <= back.freq;
         for (int i = 1; i < BACK_D; i++) begin
            back_ff[i].is_step     <= back_ff[i-1].is_step;
            back_ff[i].step_amount <= back_ff[i-1].step_amount;
            back_ff[i].freq        <= back_ff[i-1].freq;
         end
      end
   end

   // the error is the negated offset, so its sign is the opposite of the offset's
   pcs_gain_mult u_kp_mult (
      .clock (clock),
      .adv   (adv),
      .mag   (mag0),
      .neg   (~neg0),
      .gain  (prop_gain_ff),
      .prod  (kp_prod)
   );

   pcs_gain_mult u_ki_mult (
      .clock (clock),
      .adv   (adv),
      .mag   (mag0),
      .neg   (~neg0),
      .gain  (integ_gain_ff),
      .prod  (ki_prod)
   );

   pcs_pi_update u_pi (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .front    (front_ff[FRONT_D-1]),
      .kp_prod  (kp_prod),
      .ki_prod  (ki_prod),
      .max_freq (max_freq_ff),
      .back     (back)
   );

   pcs_div1000 u_div (
      .clock (clock),
      .adv   (adv),
      .freq  (back.freq),
      .quot  (quot)
   );

   // output register
   always_comb begin
      ppm_in = back_ff[BACK_D-1].freq[FREQ_W-1] ? -{1'b0, quot} : {1'b0, quot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= back_ff[BACK_D-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_is_step_ff <= back_ff[BACK_D-1].is_step;
         rsp_freq_ff    <= back_ff[BACK_D-1].freq;
         rsp_ppm_ff     <= signed'(ppm_in);
         rsp_amt_ff     <= back_ff[BACK_D-1].step_amount;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_step     = rsp_is_step_ff;
   assign rsp_freq_q16    = rsp_freq_ff;
   assign rsp_ppm_q16     = rsp_ppm_ff;
   assign rsp_step_amount = rsp_amt_ff;

endmodule
